### sv/sac_pkg.sv
// shared widths and constants for the set-associative cache hit/miss block
// no dependencies; imported by the top level
package sac_pkg;

  // byte address width of one request
  localparam int unsigned ADDR_W = 32;

  // saturating hit and miss counter width
  localparam int unsigned CNT_W = 32;

  // stream payload widths, padded to whole bytes
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 72;

  // result bit positions inside m_tdata
  localparam int unsigned M_HIT_BIT   = 0;
  localparam int unsigned M_WAY_BIT   = 1;
  localparam int unsigned M_HIT_LSB   = 2;
  localparam int unsigned M_MISS_LSB  = 34;

  // request bit positions inside s_tdata
  localparam int unsigned S_PICK_BIT = 32;

endpackage

### sv/sac_tag_ram.sv
// tag memory of the set-associative cache: one write port, one registered read port
// no dependencies; instantiated by set_assoc_cache_hit_miss
module sac_tag_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 19
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/set_assoc_cache_hit_miss.sv
// set-associative cache hit/miss tracker: tag lookup, victim way from victim_pick on a full set
// depends on sac_pkg and sac_tag_ram
// sequence: an accepted request goes to the compare step on way 0; each further way
//   examined adds a read step and a compare step; the deciding compare loads the output register
// requests: one at a time, taken only in idle; the single tag read port and compare unit walk
//   the ways in order, and a result waiting in the output register holds the final step
// reset: valid bits and both counters clear at once, tag memory is left as is
module set_assoc_cache_hit_miss
  import sac_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = 6,
  parameter int unsigned SET_BITS    = 7,
  parameter int unsigned WAYS        = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [31:0] byte_address, [32] victim_pick, [39:33] zero
  input  logic [S_TDATA_W-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [0] is_hit, [1] way_used, [33:2] hit_total, [65:34] miss_total, [71:66] zero
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int unsigned TAG_W   = ADDR_W - OFFSET_BITS - SET_BITS;
  localparam int unsigned SETS    = 1 << SET_BITS;
  localparam int unsigned ENTRIES = SETS * WAYS;
  localparam int unsigned AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP
  } state_t;

  state_t            state;
  logic [WAY_W-1:0]  way;
  logic [AW-1:0]     base;
  logic [AW-1:0]     cur_addr;
  logic [TAG_W-1:0]  tag_q;
  logic              pick_q;
  logic [ENTRIES-1:0] valid;
  logic [CNT_W-1:0]  hit_cnt;
  logic [CNT_W-1:0]  miss_cnt;

  logic              accept;
  logic [ADDR_W-1:0] in_addr;
  logic [ADDR_W-1:0] in_set;
  logic [AW-1:0]     in_base;
  logic [TAG_W-1:0]  in_tag;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [TAG_W-1:0]  rd_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;

  logic              entry_valid;
  logic              match;
  logic              decide;
  logic              out_free;
  logic              out_load;
  logic [WAY_W-1:0]  victim;
  logic [WAY_W-1:0]  chosen;
  logic [CNT_W-1:0]  hit_cnt_next;
  logic [CNT_W-1:0]  miss_cnt_next;

  // request decode
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_addr  = s_tdata[ADDR_W-1:0];
  assign in_set   = (in_addr >> OFFSET_BITS) & ADDR_W'(SETS - 1);
  assign in_base  = AW'(in_set * WAYS);
  assign in_tag   = TAG_W'(in_addr >> (OFFSET_BITS + SET_BITS));

  // victim way on a full set
  assign victim = (WAYS > 1) ? WAY_W'(pick_q) : '0;

  // shared compare unit on the way read last cycle
  assign entry_valid = valid[cur_addr];
  assign match       = entry_valid && (rd_data == tag_q);
  assign decide      = (state == S_CMP) && (!entry_valid || match || (way == LAST_WAY));
  assign out_free    = !m_tvalid || m_tready;
  assign out_load    = decide && out_free;
  assign chosen      = (!entry_valid || match) ? way : victim;

  // saturating counter steps
  assign hit_cnt_next  = (hit_cnt == '1) ? hit_cnt : hit_cnt + 1'b1;
  assign miss_cnt_next = (miss_cnt == '1) ? miss_cnt : miss_cnt + 1'b1;

  // tag memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(base + AW'(way) + 1'b1);
    if (accept) begin
      rd_en   = 1'b1;
      rd_addr = in_base;
    end else if (state == S_READ) begin
      rd_en   = 1'b1;
      rd_addr = AW'(base + AW'(way));
    end
  end

  assign wr_en   = out_load && !match;
  assign wr_addr = entry_valid ? AW'(base + AW'(victim)) : cur_addr;

  sac_tag_ram #(
    .DEPTH (ENTRIES),
    .AW    (AW),
    .DW    (TAG_W)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (tag_q),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer, valid bits, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      valid    <= '0;
      hit_cnt  <= '0;
      miss_cnt <= '0;
      m_tvalid <= 1'b0;
      way      <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            base     <= in_base;
            cur_addr <= in_base;
            tag_q    <= in_tag;
            pick_q   <= s_tdata[S_PICK_BIT];
            way      <= '0;
            state    <= S_CMP;
          end
        end
        S_READ: begin
          cur_addr <= rd_addr;
          state    <= S_CMP;
        end
        S_CMP: begin
          if (decide) begin
            if (out_free) begin
              if (!entry_valid) begin
                valid[cur_addr] <= 1'b1;
              end
              if (match) begin
                hit_cnt <= hit_cnt_next;
              end else begin
                miss_cnt <= miss_cnt_next;
              end
              // miss total, hit total, way, hit from the top down
              m_tdata <= {{(M_TDATA_W - M_MISS_LSB - CNT_W){1'b0}},
                          (match ? miss_cnt : miss_cnt_next),
                          (match ? hit_cnt_next : hit_cnt),
                          chosen[0], match};
              state <= S_IDLE;
            end
          end else begin
            way   <= WAY_W'(way + 1'b1);
            state <= S_READ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // an accepted request is compared on the next cycle
  assert property (@(posedge clk) disable iff (rst) accept |=> state == S_CMP)
    else $error("accepted request did not reach the compare step");

  // counters never move backward
  assert property (@(posedge clk) disable iff (rst) 1'b1 |=> hit_cnt >= $past(hit_cnt))
    else $error("hit counter decreased");

  assert property (@(posedge clk) disable iff (rst) 1'b1 |=> miss_cnt >= $past(miss_cnt))
    else $error("miss counter decreased");

  // every tag write comes with a miss result in the output register
  assert property (@(posedge clk) disable iff (rst)
    wr_en |=> m_tvalid && !m_tdata[M_HIT_BIT])
    else $error("tag written without a miss result");

endmodule
